// ===== rtl/indexed_binary_heap_queue_macros.svh =====
// assertion macros for the heap queue
`ifndef INDEXED_BINARY_HEAP_QUEUE_MACROS_SVH
`define INDEXED_BINARY_HEAP_QUEUE_MACROS_SVH

// implication checked in the same cycle
`define IBHQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define IBHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ibhq_pkg.sv =====
package ibhq_pkg;

  localparam int unsigned CapacityDef    = 64;
  localparam int unsigned KeyBitsDef     = 32;
  localparam int unsigned IdBits         = 6;
  localparam int unsigned NumIds         = 64;
  localparam int unsigned KeyFieldBits   = 32;
  localparam int unsigned CountFieldBits = 7;
  localparam int unsigned CmdBits        = 2;
  localparam int unsigned StatusBits     = 2;

  localparam logic [CmdBits-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CmdBits-1:0] CMD_POP    = 2'd1;
  localparam logic [CmdBits-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CmdBits-1:0] CMD_SPARE  = 2'd3;

  localparam logic [StatusBits-1:0] ST_OK     = 2'd0;
  localparam logic [StatusBits-1:0] ST_EMPTY  = 2'd1;
  localparam logic [StatusBits-1:0] ST_FULL   = 2'd2;
  localparam logic [StatusBits-1:0] ST_ABSENT = 2'd3;

endpackage

// ===== rtl/ibhq_if.sv =====
interface ibhq_in_if import ibhq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CmdBits-1:0]      cmd;
  logic [KeyFieldBits-1:0] key;
  logic [IdBits-1:0]       job_id;

  modport source (output valid, cmd, key, job_id, input ready);
  modport sink   (input valid, cmd, key, job_id, output ready);
endinterface

interface ibhq_out_if import ibhq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IdBits-1:0]         out_job_id;
  logic [KeyFieldBits-1:0]   out_key;
  logic [StatusBits-1:0]     status;
  logic [CountFieldBits-1:0] entry_count;

  modport source (output valid, out_job_id, out_key, status, entry_count, input ready);
  modport sink   (input valid, out_job_id, out_key, status, entry_count, output ready);
endinterface

interface ibhq_cfg_if ();
  logic valid;
  logic ready;
  logic order_mode;

  modport source (output valid, order_mode, input ready);
  modport sink   (input valid, order_mode, output ready);
endinterface

// ===== rtl/ibhq_ram.sv =====
module ibhq_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/ibhq_better.sv =====
module ibhq_better #(
  parameter int unsigned KeyBits = 32
) (
  input  logic               min_mode_i,
  input  logic [KeyBits-1:0] a_i,
  input  logic [KeyBits-1:0] b_i,
  output logic               better_o
);

  // strict compare, ties never move
  assign better_o = min_mode_i ? (a_i < b_i) : (a_i > b_i);

endmodule

// ===== rtl/indexed_binary_heap_queue.sv =====
// channel  dir  beat fields
// in_i     in   cmd, key, job_id
// out_o    out  out_job_id, out_key, status, entry_count
// cfg_i    in   order_mode
// one command at a time: a command rejected in S_CMD goes straight to S_OUT; otherwise
// the entry sifts up a level at a time and, for a pop or for a remove that did not move
// up, then sifts down a level at a time before the result beat, unless the last entry was taken
// the single read port of the heap memory and the one shared comparator set the pace
// rst_ni clears count, presence bits and mode; memory contents need no reset
// in_i is not ready from acceptance until the result beat leaves out_o
module indexed_binary_heap_queue import ibhq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned KEY_BITS = KeyBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ibhq_in_if.sink    in_i,
  ibhq_out_if.source out_o,
  ibhq_cfg_if.sink   cfg_i
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned NW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = PW + 2;
  localparam int unsigned EW = KEY_BITS + IdBits;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CMD    = 4'd1;
  localparam logic [3:0] S_RDPOS  = 4'd2;
  localparam logic [3:0] S_RDRES  = 4'd3;
  localparam logic [3:0] S_RDLAST = 4'd4;
  localparam logic [3:0] S_UP     = 4'd5;
  localparam logic [3:0] S_UPCMP  = 4'd6;
  localparam logic [3:0] S_UPEND  = 4'd7;
  localparam logic [3:0] S_DN     = 4'd8;
  localparam logic [3:0] S_DNL    = 4'd9;
  localparam logic [3:0] S_DNR    = 4'd10;
  localparam logic [3:0] S_DNCMP  = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0]            state_q, state_d;
  logic [NW-1:0]         cnt_q, cnt_d;
  logic [NumIds-1:0]     present_q, present_d;
  logic                  mode_q;
  logic                  moved_q, moved_d;

  logic [CmdBits-1:0]    cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [IdBits-1:0]     id_q, id_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [KEY_BITS-1:0]   cur_key_q, cur_key_d;
  logic [IdBits-1:0]     cur_id_q, cur_id_d;
  logic [KEY_BITS-1:0]   ch_key_q, ch_key_d;
  logic [IdBits-1:0]     ch_id_q, ch_id_d;
  logic [PW-1:0]         ch_pos_q, ch_pos_d;
  logic [KEY_BITS-1:0]   res_key_q, res_key_d;
  logic [IdBits-1:0]     res_id_q, res_id_d;
  logic [StatusBits-1:0] res_st_q, res_st_d;

  logic                  h_we;
  logic [PW-1:0]         h_waddr, h_raddr;
  logic [EW-1:0]         h_wdata, h_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [IdBits-1:0]     rd_id;

  logic                  p_we;
  logic [IdBits-1:0]     p_waddr;
  logic [PW-1:0]         p_wdata, p_rdata;

  logic [KEY_BITS-1:0]   cmp_a, cmp_b;
  logic                  cmp_better;

  logic [CW-1:0]         lc, rc, cnt_w;

  assign rd_key = h_rdata[EW-1:IdBits];
  assign rd_id  = h_rdata[IdBits-1:0];
  assign lc     = CW'({pos_q, 1'b1});
  assign rc     = lc + 1'b1;
  assign cnt_w  = CW'(cnt_q);

  ibhq_ram #(.Depth(CAPACITY), .Width(EW)) u_heap (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  ibhq_ram #(.Depth(NumIds), .Width(PW)) u_pos (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (id_q),
    .rdata_o (p_rdata)
  );

  ibhq_better #(.KeyBits(KEY_BITS)) u_cmp (
    .min_mode_i (mode_q),
    .a_i        (cmp_a),
    .b_i        (cmp_b),
    .better_o   (cmp_better)
  );

  assign in_i.ready        = (state_q == S_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.out_job_id  = res_id_q;
  assign out_o.out_key     = KeyFieldBits'(res_key_q);
  assign out_o.status      = res_st_q;
  assign out_o.entry_count = CountFieldBits'(cnt_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    present_d = present_q;
    moved_d   = moved_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    id_d      = id_q;
    pos_d     = pos_q;
    cur_key_d = cur_key_q;
    cur_id_d  = cur_id_q;
    ch_key_d  = ch_key_q;
    ch_id_d   = ch_id_q;
    ch_pos_d  = ch_pos_q;
    res_key_d = res_key_q;
    res_id_d  = res_id_q;
    res_st_d  = res_st_q;
    h_we      = 1'b0;
    h_waddr   = pos_q;
    h_wdata   = {cur_key_q, cur_id_q};
    h_raddr   = pos_q;
    p_we      = 1'b0;
    p_waddr   = cur_id_q;
    p_wdata   = pos_q;
    cmp_a     = cur_key_q;
    cmp_b     = rd_key;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.cmd;
          key_d   = KEY_BITS'(in_i.key);
          id_d    = in_i.job_id;
          state_d = S_CMD;
        end
      end
      S_CMD: begin
        res_key_d = '0;
        res_id_d  = '0;
        res_st_d  = ST_OK;
        moved_d   = 1'b0;
        h_raddr   = '0;
        pos_d     = '0;
        case (cmd_q)
          CMD_PUSH: begin
            if (cnt_q == NW'(CAPACITY)) begin
              res_st_d = ST_FULL;
              state_d  = S_OUT;
            end else if (present_q[id_q]) begin
              res_st_d = ST_ABSENT;
              state_d  = S_OUT;
            end else begin
              cur_key_d         = key_q;
              cur_id_d          = id_q;
              pos_d             = PW'(cnt_q);
              cnt_d             = cnt_q + 1'b1;
              present_d[id_q]   = 1'b1;
              state_d           = S_UP;
            end
          end
          CMD_POP: begin
            if (cnt_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_OUT;
            end else begin
              state_d = S_RDRES;
            end
          end
          CMD_REMOVE: begin
            if (cnt_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_OUT;
            end else if (!present_q[id_q]) begin
              res_st_d = ST_ABSENT;
              state_d  = S_OUT;
            end else begin
              state_d = S_RDPOS;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_RDPOS: begin
        h_raddr = p_rdata;
        pos_d   = p_rdata;
        if (CW'(p_rdata) >= cnt_w) begin
          res_st_d = ST_ABSENT;
          state_d  = S_OUT;
        end else begin
          state_d = S_RDRES;
        end
      end
      S_RDRES: begin
        res_key_d         = rd_key;
        res_id_d          = rd_id;
        present_d[rd_id]  = 1'b0;
        cnt_d             = cnt_q - 1'b1;
        h_raddr           = PW'(cnt_q - 1'b1);
        state_d           = S_RDLAST;
      end
      S_RDLAST: begin
        cur_key_d = rd_key;
        cur_id_d  = rd_id;
        state_d   = (CW'(pos_q) == cnt_w) ? S_OUT : S_UP;
      end
      S_UP: begin
        h_raddr = (pos_q - 1'b1) >> 1;
        state_d = (pos_q == '0) ? S_UPEND : S_UPCMP;
      end
      S_UPCMP: begin
        cmp_a = cur_key_q;
        cmp_b = rd_key;
        if (cmp_better) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = rd_id;
          pos_d   = (pos_q - 1'b1) >> 1;
          moved_d = 1'b1;
          state_d = S_UP;
        end else begin
          state_d = S_UPEND;
        end
      end
      S_UPEND: begin
        state_d = (moved_q || cmd_q == CMD_PUSH) ? S_FIN : S_DN;
      end
      S_DN: begin
        h_raddr = lc[PW-1:0];
        state_d = (lc >= cnt_w) ? S_FIN : S_DNL;
      end
      S_DNL: begin
        ch_key_d = rd_key;
        ch_id_d  = rd_id;
        ch_pos_d = lc[PW-1:0];
        h_raddr  = rc[PW-1:0];
        state_d  = (rc < cnt_w) ? S_DNR : S_DNCMP;
      end
      S_DNR: begin
        cmp_a = rd_key;
        cmp_b = ch_key_q;
        if (cmp_better) begin
          ch_key_d = rd_key;
          ch_id_d  = rd_id;
          ch_pos_d = rc[PW-1:0];
        end
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        cmp_a = ch_key_q;
        cmp_b = cur_key_q;
        if (cmp_better) begin
          h_we    = 1'b1;
          h_wdata = {ch_key_q, ch_id_q};
          p_we    = 1'b1;
          p_waddr = ch_id_q;
          pos_d   = ch_pos_q;
          state_d = S_DN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        h_we    = 1'b1;
        p_we    = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      present_q <= '0;
      mode_q    <= 1'b0;
      moved_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      present_q <= present_d;
      moved_q   <= moved_d;
      if (cfg_i.valid) begin
        mode_q <= cfg_i.order_mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    id_q      <= id_d;
    pos_q     <= pos_d;
    cur_key_q <= cur_key_d;
    cur_id_q  <= cur_id_d;
    ch_key_q  <= ch_key_d;
    ch_id_q   <= ch_id_d;
    ch_pos_q  <= ch_pos_d;
    res_key_q <= res_key_d;
    res_id_q  <= res_id_d;
    res_st_q  <= res_st_d;
  end

`include "indexed_binary_heap_queue_macros.svh"

  `IBHQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= NW'(CAPACITY), "count above capacity")
  `IBHQ_ASSERT_NOW(a_present_cnt, state_q == S_IDLE, $countones(present_q) == int'(cnt_q), "presence bits disagree with count")
  `IBHQ_ASSERT_NEXT(a_accept_cmd, in_i.valid && in_i.ready, state_q == S_CMD && !out_o.valid, "accepted beat not taken up")

endmodule

// ===== verif/indexed_binary_heap_queue_checker.sv =====
`timescale 1ns / 100ps

module indexed_binary_heap_queue_checker import ibhq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ibhq_in_if.sink      in_w,
  ibhq_out_if.sink     out_w,
  ibhq_cfg_if.sink     cfg_w,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  typedef struct packed {
    logic [IdBits-1:0]         job_id;
    logic [KeyFieldBits-1:0]   key;
    logic [StatusBits-1:0]     status;
    logic [CountFieldBits-1:0] count;
  } heap_result_t;

  logic [KeyFieldBits-1:0] slot_key [CapacityDef];
  logic [IdBits-1:0]       slot_id  [CapacityDef];
  int unsigned             pos_of   [NumIds];
  logic                    present  [NumIds];
  int unsigned             fill;
  logic                    min_mode;
  heap_result_t            expected_q [$];
  int unsigned             fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic logic wins(logic [KeyFieldBits-1:0] a, logic [KeyFieldBits-1:0] b);
    return min_mode ? (a < b) : (a > b);
  endfunction

  task automatic place(int unsigned p, logic [KeyFieldBits-1:0] k, logic [IdBits-1:0] id);
    slot_key[p] = k;
    slot_id[p]  = id;
    pos_of[id]  = p;
  endtask

  task automatic exchange(int unsigned a, int unsigned b);
    logic [KeyFieldBits-1:0] k;
    logic [IdBits-1:0]       id;
    k  = slot_key[a];
    id = slot_id[a];
    place(a, slot_key[b], slot_id[b]);
    place(b, k, id);
  endtask

  task automatic bubble_up(inout int unsigned p);
    int unsigned par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!wins(slot_key[p], slot_key[par])) break;
      exchange(p, par);
      p = par;
    end
  endtask

  task automatic bubble_down(int unsigned p);
    int unsigned c;
    while (2 * p + 1 < fill) begin
      c = 2 * p + 1;
      if (c + 1 < fill && wins(slot_key[c + 1], slot_key[c])) c = c + 1;
      if (!wins(slot_key[c], slot_key[p])) break;
      exchange(p, c);
      p = c;
    end
  endtask

  task automatic extract(int unsigned p);
    int unsigned last;
    int unsigned q;
    last = fill - 1;
    present[slot_id[p]] = 1'b0;
    fill = last;
    if (p != last) begin
      place(p, slot_key[last], slot_id[last]);
      q = p;
      bubble_up(q);
      if (q == p) bubble_down(p);
    end
  endtask

  task automatic apply_command(logic [CmdBits-1:0] cmd, logic [KeyFieldBits-1:0] key,
                               logic [IdBits-1:0] id);
    heap_result_t r;
    int unsigned  p;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (fill >= CapacityDef) r.status = ST_FULL;
      else if (present[id]) r.status = ST_ABSENT;
      else begin
        p = fill;
        fill++;
        present[id] = 1'b1;
        place(p, key, id);
        bubble_up(p);
      end
    end else if (cmd == CMD_POP) begin
      if (fill == 0) r.status = ST_EMPTY;
      else begin
        r.job_id = slot_id[0];
        r.key    = slot_key[0];
        extract(0);
      end
    end else if (cmd == CMD_REMOVE) begin
      if (fill == 0) r.status = ST_EMPTY;
      else if (!present[id]) r.status = ST_ABSENT;
      else begin
        p = pos_of[id];
        r.job_id = id;
        r.key    = slot_key[p];
        extract(p);
      end
    end
    r.count = fill[CountFieldBits-1:0];
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial begin
    fails    = 0;
    fill     = 0;
    min_mode = 1'b0;
    foreach (present[i]) present[i] = 1'b0;
  end

  always @(posedge clk_i) begin
    heap_result_t e;
    if (rst_ni) begin
      if (cfg_w.valid && cfg_w.ready) min_mode = cfg_w.order_mode;
      if (out_w.valid && out_w.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_w.out_job_id != e.job_id) report("job_id", out_w.out_job_id, e.job_id);
          if (out_w.out_key != e.key) report("key", out_w.out_key, e.key);
          if (out_w.status != e.status) report("status", out_w.status, e.status);
          if (out_w.entry_count != e.count) report("count", out_w.entry_count, e.count);
        end
      end
      if (in_w.valid && in_w.ready) apply_command(in_w.cmd, in_w.key, in_w.job_id);
    end
  end

endmodule

// ===== verif/indexed_binary_heap_queue_tb.sv =====
`timescale 1ns / 100ps

module indexed_binary_heap_queue_tb import ibhq_pkg::*; ();

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  logic        used [NumIds];
  int unsigned live;

  ibhq_in_if  in_w ();
  ibhq_out_if out_w ();
  ibhq_cfg_if cfg_w ();

  indexed_binary_heap_queue dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_w.sink),
    .out_o (out_w.source),
    .cfg_i (cfg_w.sink)
  );

  indexed_binary_heap_queue_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_w        (in_w.sink),
    .out_w       (out_w.sink),
    .cfg_w       (cfg_w.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

  // receiver stalls at random
  initial begin
    int unsigned w;
    out_w.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_w.ready && out_w.valid) begin
        w = $urandom_range(0, 19);
        if (w != 0) begin
          out_w.ready <= 1'b0;
          repeat (w) @(negedge clk_i);
        end
        out_w.ready <= 1'b1;
      end else begin
        out_w.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic [CmdBits-1:0] cmd, logic [KeyFieldBits-1:0] key,
                      logic [IdBits-1:0] id);
    int unsigned w;
    w = $urandom_range(0, 19);
    if (w != 0) begin
      in_w.valid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    in_w.valid  <= 1'b1;
    in_w.cmd    <= cmd;
    in_w.key    <= key;
    in_w.job_id <= id;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd == CMD_PUSH && !used[id] && live < CapacityDef) begin
      used[id] = 1'b1;
      live++;
    end
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_mode(logic m);
    drain();
    cfg_w.valid      <= 1'b1;
    cfg_w.order_mode <= m;
    @(posedge clk_i);
    while (!cfg_w.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_w.valid <= 1'b0;
  endtask

  function automatic logic [KeyFieldBits-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned r;
    logic [CmdBits-1:0] c;
    in_w.valid = 1'b0;
    in_w.cmd = CMD_PUSH;
    in_w.key = '0;
    in_w.job_id = '0;
    cfg_w.valid = 1'b0;
    cfg_w.order_mode = 1'b0;
    live = 0;
    foreach (used[i]) used[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    send(CMD_POP, '0, '0);
    send(CMD_REMOVE, '0, 6'd5);
    send(CMD_PUSH, 32'hFFFF_FFFF, 6'd63);
    send(CMD_PUSH, 32'h0, 6'd0);
    send(CMD_PUSH, 32'h5, 6'd7);
    send(CMD_PUSH, 32'h5, 6'd8);
    send(CMD_PUSH, 32'h1, 6'd63);
    send(CMD_REMOVE, '0, 6'd9);
    send(CMD_SPARE, 32'hFFFF_FFFF, 6'd63);
    send(CMD_REMOVE, '0, 6'd0);
    set_mode(1'b1);
    send(CMD_POP, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_POP, '0, '0);
    // fill to capacity, then push when full
    for (int i = 0; i < 64; i++) send(CMD_PUSH, rand_key(), i[5:0]);
    send(CMD_PUSH, 32'h3, 6'd1);
    for (int i = 0; i < 8; i++) send(CMD_REMOVE, '0, IdBits'($urandom_range(0, 63)));
    set_mode(1'b0);
    for (int i = 0; i < 70; i++) send(CMD_POP, '0, '0);

    for (int n = 0; n < 800; n++) begin
      if (n % 250 == 249) set_mode(1'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      if (r < 45) c = CMD_PUSH;
      else if (r < 70) c = CMD_POP;
      else if (r < 97) c = CMD_REMOVE;
      else c = CMD_SPARE;
      send(c, rand_key(), IdBits'($urandom_range(0, 63)));
    end
    set_mode(1'b1);
    for (int n = 0; n < 80; n++) send(($urandom_range(0, 1) ? CMD_PUSH : CMD_POP),
                                      rand_key(), IdBits'($urandom_range(0, 63)));

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== indexed_binary_heap_queue.f =====
+incdir+rtl
rtl/ibhq_pkg.sv
rtl/ibhq_if.sv
rtl/ibhq_ram.sv
rtl/ibhq_better.sv
rtl/indexed_binary_heap_queue.sv
verif/indexed_binary_heap_queue_checker.sv
verif/indexed_binary_heap_queue_tb.sv
